// ===== hdl/fbpa_pkg.sv =====
`default_nettype none
package fbpa_pkg;

  // Pool geometry
  localparam int unsigned MAX_BLOCKS = 256;
  localparam int unsigned IDX_W      = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  // Divider: two quotient bits per cycle
  localparam int unsigned DIV_BITS   = 2;
  localparam int unsigned DIV_STEPS  = ADDR_W / DIV_BITS;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_UNALIGNED = 3'd2;
  localparam logic [2:0] ST_RANGE     = 3'd3;
  localparam logic [2:0] ST_DOUBLE    = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd2;

  // Null link and empty head
  localparam logic [CNT_W-1:0] LINK_NULL = CNT_W'(MAX_BLOCKS);

  // Link entry of a block that is handed out
  localparam logic [CNT_W-1:0] LINK_HELD = '1;

endpackage
`default_nettype wire

// ===== hdl/fixed_block_pool_allocator.sv =====
`default_nettype none
// Allocate: the head link is read, then the block is popped and the result strobed; an empty
// pool is reported straight from idle. The next request is taken once the result is out.
// Release: the offset goes through the radix-4 offset divider, then one check-and-update step
// strobes the result; the next request is taken once the result is out.
// The receiver cannot stall: done_o marks each result for exactly one cycle.
// Reset and every configuration write rebuild the free list at once through per-entry valid bits.
module fixed_block_pool_allocator
  import fbpa_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic                 func_i,
  input  wire logic [ADDR_W-1:0]    block_address_i,
  output logic                      done_o,
  output logic [2:0]                status_o,
  output logic [ADDR_W-1:0]         granted_address_o,
  output logic [CNT_W-1:0]          free_blocks_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [ADDR_W-1:0]    cfg_wdata_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_DIV,
    S_CHECK
  } state_e;

  state_e                 state_q;
  logic [ADDR_W-1:0]      base_q;
  logic [SIZE_W-1:0]      size_q;
  logic [CNT_W-1:0]       count_q;
  logic [CNT_W-1:0]       head_q;
  logic [CNT_W-1:0]       free_q;
  logic [MAX_BLOCKS-1:0]  link_valid_q;
  logic [IDX_W-1:0]       rd_addr_q;
  logic                   rd_valid_q;
  logic [CNT_W-1:0]       rd_data_q;
  logic [IDX_W+SIZE_W-1:0] prod_q;
  logic [SIZE_W-1:0]      rem_q;
  logic [ADDR_W-1:0]      dvd_q;
  logic                   neg_q;
  logic [DIV_CNT_W-1:0]   div_cnt_q;

  logic [CNT_W-1:0]       link_mem [MAX_BLOCKS];

  logic [SIZE_W-1:0]      eff_size;
  logic [CNT_W-1:0]       eff_count;
  logic [CNT_W-1:0]       new_count;
  logic [CNT_W-1:0]       rebuild_n;
  logic [ADDR_W-1:0]      offset;
  logic                   offset_neg;
  logic [ADDR_W-1:0]      offset_mag;
  logic [SIZE_W+ADDR_W-1:0] div_next;
  logic [CNT_W-1:0]       rd_default;
  logic [CNT_W-1:0]       next_head;
  logic [IDX_W-1:0]       rel_idx;
  logic                   rel_unaligned;
  logic                   rel_range;
  logic                   rel_double;
  logic                   rel_push;
  logic                   mem_we;
  logic [IDX_W-1:0]       rd_idx;
  logic [IDX_W-1:0]       wr_idx;
  logic [CNT_W-1:0]       wr_data;
  logic                   accept;

  // Clamp a count to the pool capacity
  function automatic logic [CNT_W-1:0] clamp_count(logic [CNT_W-1:0] c);
    clamp_count = (c > LINK_NULL) ? LINK_NULL : c;
  endfunction

  // Two restoring division steps
  function automatic logic [SIZE_W+ADDR_W-1:0] div_step(logic [SIZE_W-1:0] rem,
                                                        logic [ADDR_W-1:0] dvd,
                                                        logic [SIZE_W-1:0] dsr);
    logic [SIZE_W:0]   r;
    logic [SIZE_W-1:0] rm;
    logic [ADDR_W-1:0] dv;
    rm = rem;
    dv = dvd;
    for (int k = 0; k < DIV_BITS; k++) begin
      r = {rm, dv[ADDR_W-1]};
      if (r >= {1'b0, dsr}) begin
        r  = r - {1'b0, dsr};
        dv = {dv[ADDR_W-2:0], 1'b1};
      end else begin
        dv = {dv[ADDR_W-2:0], 1'b0};
      end
      rm = r[SIZE_W-1:0];
    end
    div_step = {rm, dv};
  endfunction

  // Effective configuration and release offset
  assign eff_size   = (size_q == '0) ? SIZE_W'(1) : size_q;
  assign eff_count  = clamp_count(count_q);
  assign new_count  = clamp_count(cfg_wdata_i[CNT_W-1:0]);
  assign rebuild_n  = (cfg_index_i == CFG_BLOCK_COUNT) ? new_count : eff_count;
  assign offset     = block_address_i - base_q;
  assign offset_neg = offset[ADDR_W-1];
  assign offset_mag = offset_neg ? (~offset + ADDR_W'(1)) : offset;
  assign div_next   = div_step(rem_q, dvd_q, eff_size);
  assign accept     = start_i && (state_q == S_IDLE);
  assign busy_o     = (state_q != S_IDLE);

  // Link of an entry not written since the last rebuild
  assign rd_default = (({1'b0, rd_addr_q} + CNT_W'(1)) < eff_count)
                      ? ({1'b0, rd_addr_q} + CNT_W'(1)) : LINK_NULL;
  assign next_head  = rd_valid_q ? rd_data_q : rd_default;

  // Release checks, in priority order; the entry of the block was read on the last divider step
  assign rel_idx       = dvd_q[IDX_W-1:0];
  assign rel_unaligned = (rem_q != '0);
  assign rel_range     = (neg_q && (dvd_q != '0)) ||
                         (dvd_q >= ADDR_W'(eff_count));
  assign rel_double    = !(link_valid_q[rel_idx] && (rd_data_q == LINK_HELD));
  assign rel_push      = (state_q == S_CHECK) && !rel_unaligned && !rel_range && !rel_double;

  // Mark a popped block as held, or link a released block to the old head
  assign mem_we  = (state_q == S_ALLOC) || rel_push;
  assign wr_idx  = (state_q == S_ALLOC) ? rd_addr_q : rel_idx;
  assign wr_data = (state_q == S_ALLOC) ? LINK_HELD : head_q;

  // Read the quotient entry while dividing, else the head entry
  assign rd_idx  = (state_q == S_DIV) ? div_next[IDX_W-1:0] : head_q[IDX_W-1:0];

  // Link memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[wr_idx] <= wr_data;
    end
    rd_data_q <= link_mem[rd_idx];
  end

  // Datapath registers without reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_q <= head_q[IDX_W-1:0] * eff_size;
    end
  end

  // Control, state and registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_IDLE;
      base_q            <= '0;
      size_q            <= SIZE_W'(16);
      count_q           <= LINK_NULL;
      head_q            <= '0;
      free_q            <= LINK_NULL;
      link_valid_q      <= '0;
      rd_addr_q         <= '0;
      rd_valid_q        <= 1'b0;
      rem_q             <= '0;
      dvd_q             <= '0;
      neg_q             <= 1'b0;
      div_cnt_q         <= '0;
      done_o            <= 1'b0;
      status_o          <= ST_OK;
      granted_address_o <= '0;
      free_blocks_o     <= '0;
    end else begin
      done_o <= 1'b0;

      // Write a register and rebuild the free list
      if (cfg_we_i && (cfg_index_i <= CFG_BLOCK_COUNT)) begin
        unique case (cfg_index_i)
          CFG_POOL_BASE:   base_q  <= cfg_wdata_i;
          CFG_BLOCK_SIZE:  size_q  <= cfg_wdata_i[SIZE_W-1:0];
          CFG_BLOCK_COUNT: count_q <= cfg_wdata_i[CNT_W-1:0];
          default: ;
        endcase
        link_valid_q <= '0;
        head_q       <= (rebuild_n != '0) ? '0 : LINK_NULL;
        free_q       <= rebuild_n;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (!func_i) begin
              // Allocate: read the head link, or report empty
              if (head_q[IDX_W]) begin
                done_o            <= 1'b1;
                status_o          <= ST_EMPTY;
                granted_address_o <= '0;
                free_blocks_o     <= free_q;
              end else begin
                rd_addr_q  <= head_q[IDX_W-1:0];
                rd_valid_q <= link_valid_q[head_q[IDX_W-1:0]];
                state_q    <= S_ALLOC;
              end
            end else begin
              // Release: start dividing the offset magnitude
              rem_q     <= '0;
              dvd_q     <= offset_mag;
              neg_q     <= offset_neg;
              div_cnt_q <= DIV_CNT_W'(DIV_STEPS - 1);
              state_q   <= S_DIV;
            end
          end
        end

        S_ALLOC: begin
          // Pop the head block
          head_q                  <= next_head;
          link_valid_q[rd_addr_q] <= 1'b1;
          free_q              <= (free_q != '0) ? (free_q - CNT_W'(1)) : free_q;
          done_o              <= 1'b1;
          status_o            <= ST_OK;
          granted_address_o   <= base_q + ADDR_W'(prod_q);
          free_blocks_o       <= (free_q != '0) ? (free_q - CNT_W'(1)) : free_q;
          state_q             <= S_IDLE;
        end

        S_DIV: begin
          // Advance the divider
          rem_q     <= div_next[SIZE_W+ADDR_W-1:ADDR_W];
          dvd_q     <= div_next[ADDR_W-1:0];
          div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
          if (div_cnt_q == '0) begin
            state_q <= S_CHECK;
          end
        end

        S_CHECK: begin
          // Judge the release and push the block on success
          done_o            <= 1'b1;
          granted_address_o <= '0;
          free_blocks_o     <= free_q;
          priority if (rel_unaligned) begin
            status_o <= ST_UNALIGNED;
          end else if (rel_range) begin
            status_o <= ST_RANGE;
          end else if (rel_double) begin
            status_o <= ST_DOUBLE;
          end else begin
            status_o              <= ST_OK;
            link_valid_q[rel_idx] <= 1'b1;
            head_q                <= {1'b0, rel_idx};
            free_q                <= free_q + CNT_W'(1);
            free_blocks_o         <= free_q + CNT_W'(1);
          end
          state_q <= S_IDLE;
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
